>>> rtl/ssbc_pkg.sv
// ----------------------------------------------------------------------------
// ssbc_pkg
// Types, codes and tables shared by the six-step back-EMF commutator.
// ----------------------------------------------------------------------------
package ssbc_pkg;

    localparam int ADC_W    = 12;
    localparam int QUAL_W   = 4;
    localparam int SECTOR_W = 3;
    localparam int DUTY_W   = 14;
    localparam int COMM_W   = 16;
    localparam int GATE_W   = 6;
    localparam int PCT_W    = 8;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [SECTOR_W-1:0] LAST_SECTOR = 3'd5;
    localparam logic [DUTY_W-1:0]   DUTY_RESET  = 14'd1500;
    localparam logic [DUTY_W-1:0]   DUTY_START  = 14'd5000;
    localparam logic [PCT_W-1:0]    PCT_MAX     = 8'd100;
    localparam logic [PCT_W-1:0]    PCT_CLAMP   = 8'd95;
    localparam logic [PCT_W-1:0]    PCT_SCALE   = 8'd100;

    localparam logic [ADC_W-1:0]  THRESHOLD_RESET = 12'd2048;
    localparam logic [ADC_W-1:0]  HALF_WIN_RESET  = 12'd100;
    localparam logic [QUAL_W-1:0] QUALIFY_RESET   = 4'd3;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DUTY   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZC_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZC_HALF_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALIFY_COUNT  = 2'd2;

    // phase select codes
    localparam logic [1:0] PHASE_U = 2'd0;
    localparam logic [1:0] PHASE_V = 2'd1;
    localparam logic [1:0] PHASE_W = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADC_W-1:0]  bemf_u;
        logic [ADC_W-1:0]  bemf_v;
        logic [ADC_W-1:0]  bemf_w;
        logic [PCT_W-1:0]  duty_req;
    } t_in_item;

    typedef struct packed {
        logic                running;
        logic [SECTOR_W-1:0] sector;
        logic                zc_seen;
        logic                commutated;
        logic [COMM_W-1:0]   commutation_total;
        logic [GATE_W-1:0]   gate_pattern;
        logic [DUTY_W-1:0]   duty_counts;
    } t_out_item;

    typedef struct packed {
        logic                run_flag;
        logic [SECTOR_W-1:0] sector_index;
        logic [QUAL_W-1:0]   hit_counter;
        logic [DUTY_W-1:0]   duty_value;
        logic [COMM_W-1:0]   commutation_counter;
    } t_state;

    typedef struct packed {
        logic [ADC_W-1:0]  zc_threshold;
        logic [ADC_W-1:0]  zc_half_window;
        logic [QUAL_W-1:0] qualify_count;
    } t_cfg;

    // gate enables, bits 0..5 = UH VH WH UL VL WL
    function automatic logic [GATE_W-1:0] gate_lookup(input logic [SECTOR_W-1:0] sec);
        logic [GATE_W-1:0] g;
        case (sec)
            3'd0:    g = 6'h11;
            3'd1:    g = 6'h21;
            3'd2:    g = 6'h22;
            3'd3:    g = 6'h0A;
            3'd4:    g = 6'h0C;
            3'd5:    g = 6'h14;
            default: g = '0;
        endcase
        return g;
    endfunction

    // floating phase for each sector
    function automatic logic [1:0] watch_lookup(input logic [SECTOR_W-1:0] sec);
        logic [1:0] p;
        case (sec)
            3'd0, 3'd3: p = PHASE_W;
            3'd1, 3'd4: p = PHASE_V;
            default:    p = PHASE_U;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/ssbc_step.sv
// ----------------------------------------------------------------------------
// ssbc_step
// Next-state and result logic for one transaction of the commutator.
// ----------------------------------------------------------------------------
module ssbc_step (
    input  ssbc_pkg::t_state    i_state,
    input  ssbc_pkg::t_cfg      i_cfg,
    input  ssbc_pkg::t_in_item  i_item,
    output ssbc_pkg::t_state    o_state,
    output ssbc_pkg::t_out_item o_result
);

    logic [ssbc_pkg::SECTOR_W-1:0] sec;
    logic [ssbc_pkg::ADC_W-1:0]    reading;
    logic [ssbc_pkg::ADC_W:0]      sum_lo;
    logic [ssbc_pkg::ADC_W:0]      sum_hi;
    logic                          hit;
    logic [ssbc_pkg::QUAL_W-1:0]   need;
    logic [ssbc_pkg::QUAL_W-1:0]   hits_inc;
    logic [ssbc_pkg::PCT_W-1:0]    pct;
    logic [ssbc_pkg::DUTY_W-1:0]   duty_new;
    logic                          seen;
    logic                          moved;
    ssbc_pkg::t_state              nxt;

    assign sec = (i_state.sector_index > ssbc_pkg::LAST_SECTOR) ? '0 : i_state.sector_index;

    always_comb begin
        case (ssbc_pkg::watch_lookup(sec))
            ssbc_pkg::PHASE_U: reading = i_item.bemf_u;
            ssbc_pkg::PHASE_V: reading = i_item.bemf_v;
            default:           reading = i_item.bemf_w;
        endcase
    end

    // thr - half < r < thr + half, rearranged so nothing goes negative
    assign sum_lo = {1'b0, reading} + {1'b0, i_cfg.zc_half_window};
    assign sum_hi = {1'b0, i_cfg.zc_threshold} + {1'b0, i_cfg.zc_half_window};
    assign hit    = (sum_lo > {1'b0, i_cfg.zc_threshold}) && ({1'b0, reading} < sum_hi);

    assign need     = (i_cfg.qualify_count == '0) ? ssbc_pkg::QUAL_W'(1) : i_cfg.qualify_count;
    assign hits_inc = i_state.hit_counter + ssbc_pkg::QUAL_W'(1);

    assign pct      = (i_item.duty_req > ssbc_pkg::PCT_MAX) ? ssbc_pkg::PCT_CLAMP
                                                            : i_item.duty_req;
    assign duty_new = ssbc_pkg::DUTY_W'(pct) * ssbc_pkg::DUTY_W'(ssbc_pkg::PCT_SCALE);

    always_comb begin
        nxt   = i_state;
        seen  = 1'b0;
        moved = 1'b0;
        case (i_item.kind)
            ssbc_pkg::KIND_START: begin
                if (!i_state.run_flag) begin
                    nxt.run_flag            = 1'b1;
                    nxt.sector_index        = '0;
                    nxt.duty_value          = ssbc_pkg::DUTY_START;
                    nxt.hit_counter         = '0;
                    nxt.commutation_counter = '0;
                end
            end
            ssbc_pkg::KIND_STOP: begin
                nxt.run_flag = 1'b0;
            end
            ssbc_pkg::KIND_DUTY: begin
                nxt.duty_value = duty_new;
            end
            default: begin
                if (i_state.run_flag) begin
                    if (hit) begin
                        seen = 1'b1;
                        if (hits_inc >= need) begin
                            nxt.sector_index = (sec >= ssbc_pkg::LAST_SECTOR)
                                             ? '0 : sec + ssbc_pkg::SECTOR_W'(1);
                            nxt.commutation_counter =
                                i_state.commutation_counter + ssbc_pkg::COMM_W'(1);
                            nxt.hit_counter  = '0;
                            moved            = 1'b1;
                        end else begin
                            nxt.hit_counter = hits_inc;
                        end
                    end else begin
                        nxt.hit_counter = '0;
                    end
                end
            end
        endcase
    end

    assign o_state = nxt;

    always_comb begin
        o_result.running           = nxt.run_flag;
        o_result.sector            = nxt.sector_index;
        o_result.zc_seen           = seen;
        o_result.commutated        = moved;
        o_result.commutation_total = nxt.commutation_counter;
        o_result.gate_pattern      = nxt.run_flag ? ssbc_pkg::gate_lookup(nxt.sector_index)
                                                  : '0;
        o_result.duty_counts       = nxt.duty_value;
    end

endmodule

>>> rtl/six_step_bemf_commutator_unit.sv
// ----------------------------------------------------------------------------
// six_step_bemf_commutator_unit
// Sensorless six-step commutator: back-EMF window detection, sector stepping
// and gate pattern / duty output, one result per input transaction.
// ----------------------------------------------------------------------------
//  channel   direction   signals                               payload
//  input     in          i_in_valid / o_in_ready               i_in_data  (t_in_item)
//  result    out         o_out_valid / i_out_ready             o_out_data (t_out_item)
//  config    in          i_cfg_valid / o_cfg_ready             i_cfg_index, i_cfg_data
//
//  One transaction per cycle sustained while the result side is not stalled; each
//  passes the input register, then the result register, with the state update between them.
//  Reset (i_rst_n low at a clock edge) returns idle state, duty 1500 counts
//  and the default configuration. A stalled result holds the input register;
//  the input side keeps accepting while that register is free.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
module six_step_bemf_commutator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ssbc_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ssbc_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssbc_pkg::ADC_W-1:0]       i_cfg_data
);

    logic                r_in_valid;
    ssbc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    ssbc_pkg::t_out_item r_out;
    ssbc_pkg::t_state    r_state;
    ssbc_pkg::t_state    n_state;
    ssbc_pkg::t_cfg      r_cfg;
    ssbc_pkg::t_out_item n_out;
    logic                advance;

    ssbc_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.run_flag            <= 1'b0;
            r_state.sector_index        <= '0;
            r_state.hit_counter         <= '0;
            r_state.duty_value          <= ssbc_pkg::DUTY_RESET;
            r_state.commutation_counter <= '0;
            r_cfg.zc_threshold   <= ssbc_pkg::THRESHOLD_RESET;
            r_cfg.zc_half_window <= ssbc_pkg::HALF_WIN_RESET;
            r_cfg.qualify_count  <= ssbc_pkg::QUALIFY_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                if (i_in_valid) begin
                    r_in <= i_in_data;
                end
            end
            if (advance) begin
                r_state     <= n_state;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ssbc_pkg::CFG_ZC_THRESHOLD:   r_cfg.zc_threshold   <= i_cfg_data;
                    ssbc_pkg::CFG_ZC_HALF_WINDOW: r_cfg.zc_half_window <= i_cfg_data;
                    ssbc_pkg::CFG_QUALIFY_COUNT:
                        r_cfg.qualify_count <= i_cfg_data[ssbc_pkg::QUAL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> verif/six_step_bemf_commutator_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_step_bemf_commutator_unit_checker
// Watches the input, result and register channels of the commutator. It
// keeps its own copy of the motor state to predict each result, then checks
// the results in order, field by field.
// ----------------------------------------------------------------------------
module six_step_bemf_commutator_unit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  ssbc_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  ssbc_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ssbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssbc_pkg::ADC_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam logic [ssbc_pkg::DUTY_W-1:0] DUTY_AFTER_RESET = 14'd1500;
    localparam logic [ssbc_pkg::DUTY_W-1:0] DUTY_ON_START    = 14'd5000;

    // register copies
    logic [ssbc_pkg::ADC_W-1:0]    zc_centre = 12'd2048;
    logic [ssbc_pkg::ADC_W-1:0]    zc_half   = 12'd100;
    logic [ssbc_pkg::QUAL_W-1:0]   qualify   = 4'd3;

    // motor state copies
    logic                          motor_on   = 1'b0;
    logic [ssbc_pkg::SECTOR_W-1:0] sector     = '0;
    logic [ssbc_pkg::QUAL_W-1:0]   hits       = '0;
    logic [ssbc_pkg::DUTY_W-1:0]   duty       = DUTY_AFTER_RESET;
    logic [ssbc_pkg::COMM_W-1:0]   comm_total = '0;

    ssbc_pkg::t_out_item predicted_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic ssbc_pkg::t_out_item commutate(input ssbc_pkg::t_in_item item);
        ssbc_pkg::t_out_item         r;
        int                          reading;
        int                          lo;
        int                          hi;
        int                          c;
        int                          h;
        logic [ssbc_pkg::QUAL_W-1:0] need;
        logic [ssbc_pkg::PCT_W-1:0]  pct;
        r = '0;
        case (item.kind)
            ssbc_pkg::KIND_START: begin
                if (!motor_on) begin
                    motor_on   = 1'b1;
                    sector     = '0;
                    duty       = DUTY_ON_START;
                    hits       = '0;
                    comm_total = '0;
                end
            end
            ssbc_pkg::KIND_STOP: begin
                motor_on = 1'b0;
            end
            ssbc_pkg::KIND_DUTY: begin
                pct  = (item.duty_req > 8'd100) ? 8'd95 : item.duty_req;
                duty = 14'(pct) * 14'd100;
            end
            default: begin
                if (motor_on) begin
                    // the floating phase of the sector carries the back-EMF
                    case (sector)
                        3'd0, 3'd3: reading = item.bemf_w;
                        3'd1, 3'd4: reading = item.bemf_v;
                        default:    reading = item.bemf_u;
                    endcase
                    c    = zc_centre;
                    h    = zc_half;
                    lo   = c - h;
                    hi   = c + h;
                    need = (qualify == 4'd0) ? 4'd1 : qualify;
                    if (reading > lo && reading < hi) begin
                        r.zc_seen = 1'b1;
                        hits      = hits + 4'd1;
                        if (hits >= need) begin
                            sector       = (sector == 3'd5) ? 3'd0 : sector + 3'd1;
                            comm_total   = comm_total + 16'd1;
                            hits         = '0;
                            r.commutated = 1'b1;
                        end
                    end else begin
                        hits = '0;
                    end
                end
            end
        endcase
        r.running           = motor_on;
        r.sector            = sector;
        r.commutation_total = comm_total;
        r.duty_counts       = duty;
        if (motor_on) begin
            case (sector)
                3'd0:    r.gate_pattern = 6'h11;
                3'd1:    r.gate_pattern = 6'h21;
                3'd2:    r.gate_pattern = 6'h22;
                3'd3:    r.gate_pattern = 6'h0A;
                3'd4:    r.gate_pattern = 6'h0C;
                default: r.gate_pattern = 6'h14;
            endcase
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        ssbc_pkg::t_out_item want;
        if (!i_rst_n) begin
            zc_centre  = 12'd2048;
            zc_half    = 12'd100;
            qualify    = 4'd3;
            motor_on   = 1'b0;
            sector     = '0;
            hits       = '0;
            duty       = DUTY_AFTER_RESET;
            comm_total = '0;
            predicted_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("running", want.running, i_out_data.running);
                    check_field("sector", want.sector, i_out_data.sector);
                    check_field("zc_seen", want.zc_seen, i_out_data.zc_seen);
                    check_field("commutated", want.commutated, i_out_data.commutated);
                    check_field("commutation_total", want.commutation_total,
                                i_out_data.commutation_total);
                    check_field("gate_pattern", want.gate_pattern, i_out_data.gate_pattern);
                    check_field("duty_counts", want.duty_counts, i_out_data.duty_counts);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ssbc_pkg::CFG_ZC_THRESHOLD:   zc_centre = i_cfg_data;
                    ssbc_pkg::CFG_ZC_HALF_WINDOW: zc_half   = i_cfg_data;
                    ssbc_pkg::CFG_QUALIFY_COUNT:  qualify   = i_cfg_data[ssbc_pkg::QUAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predicted_results.push_back(commutate(i_in_data));
        end
        o_pending = predicted_results.size();
    end

endmodule

>>> verif/six_step_bemf_commutator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_step_bemf_commutator_unit_tb
// Drives the commutator with a directed start/stop/duty/window sequence, then
// randomised motor runs over several window and qualify settings, with
// random stalls on both sides and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module six_step_bemf_commutator_unit_tb;

    localparam logic [ssbc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register slot
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    ssbc_pkg::t_in_item             in_data   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    ssbc_pkg::t_out_item            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ssbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ssbc_pkg::ADC_W-1:0]     cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic idling_on   = 1'b1;
    logic hold_req    = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    six_step_bemf_commutator_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    six_step_bemf_commutator_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: random stalls, plus one long hold on request
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic ssbc_pkg::t_in_item build_item(input logic [ssbc_pkg::KIND_W-1:0] kind,
                                                      input int u, input int v, input int w,
                                                      input int pct);
        ssbc_pkg::t_in_item item;
        item.kind     = kind;
        item.bemf_u   = 12'(u);
        item.bemf_v   = 12'(v);
        item.bemf_w   = 12'(w);
        item.duty_req = 8'(pct);
        return item;
    endfunction

    // mostly inside the window, some on its edges, the rest anywhere
    function automatic int aimed_reading(input int centre, input int half, input int hit_pct);
        int lo;
        int hi;
        int r;
        lo = centre - half + 1;
        hi = centre + half - 1;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        if ($urandom_range(0, 99) < hit_pct && lo <= hi) begin
            r = $urandom_range(hi, lo);
        end else if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
                0:       r = centre - half;
                1:       r = centre + half;
                2:       r = centre - half + 1;
                default: r = centre + half - 1;
            endcase
            if (r < 0) r = 0;
            if (r > 4095) r = 4095;
        end else begin
            r = $urandom_range(0, 4095);
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_command(input ssbc_pkg::t_in_item item);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [ssbc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ssbc_pkg::ADC_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input int centre, input int half,
                             input logic [ssbc_pkg::ADC_W-1:0] qual_data,
                             input int n_items, input int hit_pct, input bit pressure);
        int                          sel;
        logic [ssbc_pkg::KIND_W-1:0] kind;
        int                          pct;
        wait_drained();
        write_register(ssbc_pkg::CFG_ZC_THRESHOLD, 12'(centre));
        write_register(ssbc_pkg::CFG_ZC_HALF_WINDOW, 12'(half));
        write_register(ssbc_pkg::CFG_QUALIFY_COUNT, qual_data);
        cfg_valid <= 1'b0;
        if (pressure)
            hold_req <= 1'b1;
        send_command(build_item(ssbc_pkg::KIND_START, $urandom_range(0, 4095),
                                $urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, 255)));
        repeat (n_items - 1) begin
            sel = $urandom_range(0, 99);
            if (sel < 86)
                kind = ssbc_pkg::KIND_SAMPLE;
            else if (sel < 91)
                kind = ssbc_pkg::KIND_START;
            else if (sel < 94)
                kind = ssbc_pkg::KIND_STOP;
            else
                kind = ssbc_pkg::KIND_DUTY;
            pct = $urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom_range(0, 255);
            send_command(build_item(kind, aimed_reading(centre, half, hit_pct),
                                    aimed_reading(centre, half, hit_pct),
                                    aimed_reading(centre, half, hit_pct), pct));
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: window 1948 < x < 2148, three hits to commutate
        send_command(build_item(ssbc_pkg::KIND_SAMPLE, 0, 4095, 2048, 0));   // idle, ignored
        send_command(build_item(ssbc_pkg::KIND_STOP, 4095, 0, 0, 255));      // idle, ignored
        send_command(build_item(ssbc_pkg::KIND_DUTY, 0, 0, 0, 0));
        send_command(build_item(ssbc_pkg::KIND_DUTY, 0, 0, 0, 100));
        send_command(build_item(ssbc_pkg::KIND_DUTY, 0, 0, 0, 101));         // clamped
        send_command(build_item(ssbc_pkg::KIND_DUTY, 0, 0, 0, 255));         // clamped
        send_command(build_item(ssbc_pkg::KIND_START, 0, 0, 0, 0));
        send_command(build_item(ssbc_pkg::KIND_START, 0, 0, 0, 0));          // already running
        send_command(build_item(ssbc_pkg::KIND_SAMPLE, 4095, 0, 1948, 0));   // edges exclusive
        send_command(build_item(ssbc_pkg::KIND_SAMPLE, 4095, 0, 2148, 0));
        send_command(build_item(ssbc_pkg::KIND_SAMPLE, 4095, 0, 1949, 0));
        send_command(build_item(ssbc_pkg::KIND_SAMPLE, 4095, 0, 2147, 0));
        send_command(build_item(ssbc_pkg::KIND_SAMPLE, 0, 4095, 4095, 0));   // miss clears run
        repeat (3) send_command(build_item(ssbc_pkg::KIND_SAMPLE, 0, 0, 2048, 0));
        repeat (3) send_command(build_item(ssbc_pkg::KIND_SAMPLE, 4095, 2100, 0, 0));
        send_command(build_item(ssbc_pkg::KIND_DUTY, 0, 0, 0, 50));
        send_command(build_item(ssbc_pkg::KIND_STOP, 0, 0, 0, 0));
        send_command(build_item(ssbc_pkg::KIND_SAMPLE, 2048, 2048, 2048, 0));
        send_command(build_item(ssbc_pkg::KIND_START, 0, 0, 0, 0));          // restart, sector 0
        in_valid <= 1'b0;

        run_phase(2048, 100, 12'h003, 125, 70, 1'b0);
        run_phase(0, 4095, 12'h001, 125, 70, 1'b0);
        run_phase(4095, 4095, 12'hFFF, 125, 97, 1'b0);

        wait_drained();
        write_register(CFG_SPARE, 12'($urandom_range(0, 4095)));
        cfg_valid <= 1'b0;

        // zero half-width never hits; qualify of zero acts as one
        run_phase($urandom_range(0, 4095), 0, 12'hFF0, 100, 70, 1'b0);
        run_phase($urandom_range(0, 4095), $urandom_range(1, 300), 12'h5A0, 100, 75, 1'b0);
        run_phase($urandom_range(0, 4095), $urandom_range(0, 600),
                  12'($urandom_range(0, 4095) | 1), 125, 85, 1'b1);

        idling_on <= 1'b0;
        run_phase($urandom_range(0, 4095), $urandom_range(0, 4095),
                  12'($urandom_range(0, 4095)), 175, 80, 1'b0);

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
